// File: rtl/tsm_pkg.sv
`default_nettype none

package tsm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    // Command codes carried on the action field
    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_MERGE  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

endpackage

`default_nettype wire

// File: rtl/tsm_list_ram.sv
`default_nettype none

module tsm_list_ram
    import tsm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_we,
    input  wire t_idx  i_waddr,
    input  wire t_data i_wdata,
    input  wire        i_re,
    input  wire t_idx  i_raddr,
    output t_data      o_rdata
);

    t_data r_mem [LIST_DEPTH];
    t_data r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold the last word while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/two_way_sorted_merge.sv
`default_nettype none

// A load leaves the block idle, so start is taken again in the next cycle.
// A merge of N held elements keeps busy high for its N beats: both list heads are
// read at the accepting edge, then one beat per cycle, set by the single read
// port of each list memory. A merge of two empty lists gives its beat next cycle.
// Results are strobed for one cycle; the receiver cannot stall them.
// Synchronous active-low reset clears counts, overflow flag and sequencer.
module two_way_sorted_merge
    import tsm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_action,
    input  wire  [31:0] i_value,
    output logic        o_strobe,
    output logic [31:0] o_merged_value,
    output logic        o_last,
    output logic        o_empty_res,
    output logic        o_dropped
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    t_cnt   r_idx_a, n_idx_a, r_idx_b, n_idx_b;
    logic   r_ovf, n_ovf;

    logic   r_strobe, n_strobe;
    t_data  r_val, n_val;
    logic   r_last, n_last, r_empty, n_empty, r_drop, n_drop;

    logic   accept;
    logic   we_a, we_b, re_a, re_b;
    t_idx   raddr_a, raddr_b;
    t_data  rd_a, rd_b;
    logic   take_a;
    t_cnt   idx_a_inc, idx_b_inc;
    logic [CNT_W:0] done_cnt, total_cnt;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign idx_a_inc = r_idx_a + t_cnt'(1);
    assign idx_b_inc = r_idx_b + t_cnt'(1);
    assign done_cnt  = {1'b0, r_idx_a} + {1'b0, r_idx_b} + {{CNT_W{1'b0}}, 1'b1};
    assign total_cnt = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};

    // Pick the smaller head; A wins a tie
    always_comb begin
        if (r_idx_a >= r_cnt_a) begin
            take_a = 1'b0;
        end else if (r_idx_b >= r_cnt_b) begin
            take_a = 1'b1;
        end else begin
            take_a = (rd_a <= rd_b);
        end
    end

    // Memory port control
    always_comb begin
        we_a    = accept && (t_action'(i_action) == ACT_LOAD_A)
                  && (r_cnt_a < t_cnt'(LIST_DEPTH));
        we_b    = accept && (t_action'(i_action) == ACT_LOAD_B)
                  && (r_cnt_b < t_cnt'(LIST_DEPTH));
        re_a    = 1'b0;
        re_b    = 1'b0;
        raddr_a = '0;
        raddr_b = '0;
        if (accept && (t_action'(i_action) == ACT_MERGE)) begin
            re_a = 1'b1;
            re_b = 1'b1;
        end else if (r_state == S_EMIT) begin
            re_a    = take_a;
            re_b    = !take_a;
            raddr_a = idx_a_inc[IDX_W-1:0];
            raddr_b = idx_b_inc[IDX_W-1:0];
        end
    end

    // Sequencer, counts and result beat
    always_comb begin
        n_state  = r_state;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_idx_a  = r_idx_a;
        n_idx_b  = r_idx_b;
        n_ovf    = r_ovf;
        n_strobe = 1'b0;
        n_val    = r_val;
        n_last   = 1'b0;
        n_empty  = 1'b0;
        n_drop   = r_drop;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_LOAD_A: begin
                            if (we_a) n_cnt_a = r_cnt_a + t_cnt'(1);
                            else      n_ovf   = 1'b1;
                        end
                        ACT_LOAD_B: begin
                            if (we_b) n_cnt_b = r_cnt_b + t_cnt'(1);
                            else      n_ovf   = 1'b1;
                        end
                        ACT_MERGE: begin
                            n_idx_a = '0;
                            n_idx_b = '0;
                            if (total_cnt == '0) begin
                                // Both lists empty: one flagged beat
                                n_strobe = 1'b1;
                                n_val    = '0;
                                n_last   = 1'b1;
                                n_empty  = 1'b1;
                                n_drop   = r_ovf;
                                n_ovf    = 1'b0;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_drop   = r_ovf;
                if (take_a) begin
                    n_val   = rd_a;
                    n_idx_a = idx_a_inc;
                end else begin
                    n_val   = rd_b;
                    n_idx_b = idx_b_inc;
                end
                if (done_cnt == total_cnt) begin
                    n_last  = 1'b1;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx_a <= n_idx_a;
        r_idx_b <= n_idx_b;
        r_val   <= n_val;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_drop  <= n_drop;
    end

    tsm_list_ram u_list_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (t_data'(i_value)),
        .i_re    (re_a),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    tsm_list_ram u_list_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (t_data'(i_value)),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    assign o_strobe       = r_strobe;
    assign o_merged_value = r_val;
    assign o_last         = r_strobe && r_last;
    assign o_empty_res    = r_strobe && r_empty;
    assign o_dropped      = r_strobe && r_drop;

    // Read pointers never run past the fill counts while emitting
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_idx_a <= r_cnt_a) && (r_idx_b <= r_cnt_b)))
        else $error("merge pointer beyond list fill");

    // Every beat comes from the emit state or an empty merge command
    a_beat_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state == S_EMIT)
                      || ($past(accept) && $past(i_action) == ACT_MERGE)))
        else $error("result beat without a merge");

    // The final beat of a run leaves the block ready with cleared counts
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (!busy && r_cnt_a == '0 && r_cnt_b == '0 && !r_ovf))
        else $error("merge did not close cleanly");

    // An empty beat is single, last and zero
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty_res |-> (o_last && o_merged_value == '0))
        else $error("malformed empty result");

endmodule

`default_nettype wire

// File: verif/two_way_sorted_merge_tb.sv
`timescale 1ns / 100ps

module two_way_sorted_merge_tb;
    import tsm_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 20;

    typedef struct packed {
        t_data value;
        logic  last;
        logic  empty_res;
        logic  dropped;
    } t_merge_beat;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_action i_action = ACT_NONE;
    t_data   i_value  = '0;
    logic        busy;
    logic        o_strobe;
    logic [31:0] o_merged_value;
    logic        o_last;
    logic        o_empty_res;
    logic        o_dropped;

    // Shadow copy of the two lists, their fill counts and the overflow flag
    t_data held_a [LIST_DEPTH];
    t_data held_b [LIST_DEPTH];
    int    held_a_cnt    = 0;
    int    held_b_cnt    = 0;
    logic  overflow_flag = 1'b0;

    t_merge_beat expected_beats[$];
    int fail_count  = 0;
    int items_sent  = 0;
    int idle_pct    = 21;
    int cycle_count = 0;

    two_way_sorted_merge DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_merged_value (o_merged_value),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_dropped      (o_dropped)
    );

    always #2 i_clk = ~i_clk;

    // Count cycles for the run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("two_way_sorted_merge verification failed");
        $finish;
    end

    // Work out the beats that one accepted command produces
    task automatic predict_beats(input t_action act, input t_data val);
        int          ia;
        int          ib;
        int          total;
        int          k;
        logic        take_a;
        t_merge_beat beat;
        ia = 0;
        ib = 0;
        k  = 0;
        case (act)
            ACT_LOAD_A: begin
                if (held_a_cnt < LIST_DEPTH) begin
                    held_a[held_a_cnt] = val;
                    held_a_cnt++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            ACT_LOAD_B: begin
                if (held_b_cnt < LIST_DEPTH) begin
                    held_b[held_b_cnt] = val;
                    held_b_cnt++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            ACT_MERGE: begin
                total = held_a_cnt + held_b_cnt;
                if (total == 0) begin
                    beat = '{value: '0, last: 1'b1, empty_res: 1'b1, dropped: overflow_flag};
                    expected_beats.push_back(beat);
                end else begin
                    // Smaller head first; A wins a tie
                    while (ia < held_a_cnt || ib < held_b_cnt) begin
                        if (ia >= held_a_cnt)
                            take_a = 1'b0;
                        else if (ib >= held_b_cnt)
                            take_a = 1'b1;
                        else
                            take_a = (held_a[ia] <= held_b[ib]);
                        beat.value = take_a ? held_a[ia] : held_b[ib];
                        if (take_a)
                            ia++;
                        else
                            ib++;
                        k++;
                        beat.last      = (k == total);
                        beat.empty_res = 1'b0;
                        beat.dropped   = overflow_flag;
                        expected_beats.push_back(beat);
                    end
                end
                held_a_cnt    = 0;
                held_b_cnt    = 0;
                overflow_flag = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Drive one command beat, optionally after a random gap, and hold it until taken
    task automatic send_beat(input t_action act, input t_data val);
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        @(negedge i_clk);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_beats(act, val);
        items_sent++;
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin : check_beats
        t_merge_beat want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: merged_value %0d last %0b",
                       $signed(o_merged_value), o_last);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_merged_value !== want.value) begin
                    $error("merged_value: expected %0d, got %0d",
                           want.value, $signed(o_merged_value));
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_count++;
                end
                if (o_empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0b, got %0b", want.empty_res, o_empty_res);
                    fail_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %0b, got %0b", want.dropped, o_dropped);
                    fail_count++;
                end
            end
        end
    end

    function automatic t_data rand_value(input int mode);
        case (mode)
            0: return t_data'($urandom);
            1: return t_data'(int'($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return '0;
                    3: return -1;
                    default: return t_data'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic void sort_ascending(ref t_data vals[$]);
        t_data tmp;
        int    j;
        for (int i = 1; i < vals.size(); i++) begin
            tmp = vals[i];
            j   = i - 1;
            while (j >= 0 && vals[j] > tmp) begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = tmp;
        end
    endfunction

    // Load two lists with interleaved beats and some noise, then merge
    task automatic run_merge_sequence(input int na, input int nb, input bit sorted_lists,
                                      input int mode);
        t_data list_a[$];
        t_data list_b[$];
        int    ia;
        int    ib;
        bit    pick_a;
        ia = 0;
        ib = 0;
        repeat (na) list_a.push_back(rand_value(mode));
        repeat (nb) list_b.push_back(rand_value(mode));
        if (sorted_lists) begin
            sort_ascending(list_a);
            sort_ascending(list_b);
        end
        while (ia < list_a.size() || ib < list_b.size()) begin
            if ($urandom_range(19) == 0)
                send_beat(ACT_NONE, rand_value(0));
            pick_a = (ib >= list_b.size()) || (ia < list_a.size() && $urandom_range(1) == 1);
            if (pick_a) begin
                send_beat(ACT_LOAD_A, list_a[ia]);
                ia++;
            end else begin
                send_beat(ACT_LOAD_B, list_b[ib]);
                ib++;
            end
        end
        send_beat(ACT_MERGE, rand_value(0));
    endtask

    function automatic int rand_list_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6);
        else if (r < 85)
            return $urandom_range(31, 7);
        else
            return $urandom_range(LIST_DEPTH + 4, LIST_DEPTH);
    endfunction

    task automatic test_empty_merge();
        send_beat(ACT_MERGE, 32'sh7FFF_FFFF);
        send_beat(ACT_MERGE, '0);
    endtask

    // Extremes on both lists with ties at the bottom, middle and top
    task automatic test_extreme_values();
        send_beat(ACT_LOAD_A, 32'sh8000_0000);
        send_beat(ACT_LOAD_B, 32'sh8000_0000);
        send_beat(ACT_LOAD_A, -1);
        send_beat(ACT_LOAD_A, '0);
        send_beat(ACT_LOAD_B, '0);
        send_beat(ACT_LOAD_B, 1);
        send_beat(ACT_LOAD_B, 32'sh7FFF_FFFF);
        send_beat(ACT_LOAD_A, 32'sh7FFF_FFFF);
        send_beat(ACT_MERGE, -1);
    endtask

    // One list empty while the other drains on its own
    task automatic test_single_list();
        send_beat(ACT_LOAD_A, 5);
        send_beat(ACT_MERGE, '0);
        send_beat(ACT_LOAD_B, -5);
        send_beat(ACT_LOAD_B, 32'sh5555_AAAA);
        send_beat(ACT_MERGE, '0);
    endtask

    // The spare code must leave the lists untouched
    task automatic test_unused_action();
        send_beat(ACT_LOAD_A, 7);
        send_beat(ACT_NONE, -1);
        send_beat(ACT_NONE, '0);
        send_beat(ACT_MERGE, '0);
        send_beat(ACT_NONE, 32'sh1234_5678);
        send_beat(ACT_MERGE, '0);
    endtask

    // Fill to depth, and past it so the drop flag shows on the merge
    task automatic test_depth_limits();
        run_merge_sequence(LIST_DEPTH, LIST_DEPTH, 1'b1, 0);
        run_merge_sequence(LIST_DEPTH + 2, 0, 1'b1, 1);
        run_merge_sequence(3, LIST_DEPTH + 1, 1'b1, 2);
        run_merge_sequence(LIST_DEPTH + 1, LIST_DEPTH + 1, 1'b0, 0);
    endtask

    task automatic test_random_merges(input int sender_idle, input int item_target);
        int first;
        first    = items_sent;
        idle_pct = sender_idle;
        while (items_sent - first < item_target)
            run_merge_sequence(rand_list_size(), rand_list_size(),
                               $urandom_range(9) != 0, $urandom_range(2));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_merge();
        test_extreme_values();
        test_single_list();
        test_unused_action();
        test_depth_limits();
        test_random_merges(21, 35);
        test_random_merges(77, 35);
        test_random_merges(0, 35);

        // Release start and let the last merge drain
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("two_way_sorted_merge verification clean");
        else
            $display("two_way_sorted_merge verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tsm_pkg.sv
rtl/tsm_list_ram.sv
rtl/two_way_sorted_merge.sv
verif/two_way_sorted_merge_tb.sv
